// ----- src/assert_macros.svh -----
// Assertion macros shared by the linear parameter ramp RTL.
// No dependencies; included by every file that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPR_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/lpr_pkg.sv -----
// Package for the linear parameter ramp: widths, codes, state and control types.
// No dependencies; used by every other file of the block except assert_macros.svh.
`timescale 1ns / 1ps

package lpr_pkg;

    localparam int VAL_W    = 32;
    localparam int SMP_W    = 24;
    localparam int LEN_W    = 16;
    localparam int MINCH_W  = 24;
    localparam int CFG_D_W  = 24;
    localparam int PROD_W   = VAL_W + SMP_W;
    localparam int MAG_W    = VAL_W + 1;

    localparam int MIN_RAMP_LENGTH_DEF = 1;

    localparam logic [LEN_W-1:0]   RAMP_LENGTH_RESET = 16'd480;
    localparam logic [MINCH_W-1:0] MIN_CHANGE_RESET  = 24'd16;

    localparam logic [VAL_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        OP_SET  = 2'd0,
        OP_ADD  = 2'd1,
        OP_MUL  = 2'd2,
        OP_EMIT = 2'd3
    } t_opcode;

    typedef enum logic {
        REG_RAMP_LENGTH = 1'b0,
        REG_MIN_CHANGE  = 1'b1
    } t_cfg_index;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_UPDATE,
        S_ADVANCE,
        S_CALC,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic check;
        logic div_start;
        logic update;
        logic advance;
        logic calc;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic big_change;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

// ----- src/lpr_in_if.sv -----
// Input item channel of the linear parameter ramp.
// Depends on lpr_pkg for the opcode type and field widths.
`timescale 1ns / 1ps

interface lpr_in_if
    import lpr_pkg::*;
();
    logic                    valid;
    logic                    ready;
    t_opcode                 opcode;
    logic signed [VAL_W-1:0] new_target;
    logic                    skip_ramp;
    logic signed [SMP_W-1:0] sample_in;

    modport source (output valid, output opcode, output new_target, output skip_ramp,
                    output sample_in, input ready);
    modport sink   (input valid, input opcode, input new_target, input skip_ramp,
                    input sample_in, output ready);
endinterface

// ----- src/lpr_out_if.sv -----
// Result item channel of the linear parameter ramp.
// Depends on lpr_pkg for field widths.
`timescale 1ns / 1ps

interface lpr_out_if
    import lpr_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] sample_out;
    logic                    ramping;

    modport source (output valid, output sample_out, output ramping, input ready);
    modport sink   (input valid, input sample_out, input ramping, output ready);
endinterface

// ----- src/lpr_cfg_if.sv -----
// Configuration write channel of the linear parameter ramp.
// Depends on lpr_pkg for the register index type and data width.
`timescale 1ns / 1ps

interface lpr_cfg_if
    import lpr_pkg::*;
();
    logic               valid;
    logic               ready;
    t_cfg_index         reg_index;
    logic [CFG_D_W-1:0] wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

// ----- src/lpr_div.sv -----
// Restoring divider, one quotient bit per cycle, for the ramp step computation.
// Depends on lpr_pkg (package import only) and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lpr_div
    import lpr_pkg::*;
#(
    parameter int DVD_W = MAG_W,
    parameter int DVS_W = LEN_W
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic [DVD_W-1:0] o_quotient,
    output logic             o_done
);
    localparam int CNT_W = $clog2(DVD_W);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVS_W-1:0] r_dvs, n_dvs;
    logic [DVD_W-1:0] r_quo, n_quo;
    logic [DVS_W:0]   w_trial;
    logic [DVS_W:0]   w_diff;

    assign w_trial = {r_rem, r_quo[DVD_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CNT_W'(DVD_W - 1);
            n_rem  = '0;
            n_dvs  = i_divisor;
            n_quo  = i_dividend;
        end else if (r_busy) begin
            // The dividend shifts out at the top while quotient bits enter below.
            if (!w_diff[DVS_W]) begin
                n_rem = w_diff[DVS_W-1:0];
                n_quo = {r_quo[DVD_W-2:0], 1'b1};
            end else begin
                n_rem = w_trial[DVS_W-1:0];
                n_quo = {r_quo[DVD_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - CNT_W'(1);
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_quo <= n_quo;
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

    `LPR_ASSERT_NEXT(a_div_last_step, i_clk, i_rst_n, r_busy && !i_start && r_cnt == '0,
        r_done && !r_busy, "divider did not finish after its last step")
endmodule

// ----- src/lpr_ctrl.sv -----
// Controller state machine of the linear parameter ramp.
// Depends on lpr_pkg for the state, command and status types, and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lpr_ctrl
    import lpr_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_opcode i_opcode,
    input  t_status i_status,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);
    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_opcode == OP_SET) ? S_CHECK : S_ADVANCE;
                end
            end
            S_CHECK:   n_state = i_status.big_change ? S_DIV : S_UPDATE;
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE:  n_state = S_IDLE;
            S_ADVANCE: n_state = S_CALC;
            S_CALC:    n_state = S_FINISH;
            S_FINISH: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_CHECK: begin
                o_cmd.check     = 1'b1;
                o_cmd.div_start = i_status.big_change;
            end
            S_UPDATE:  o_cmd.update  = 1'b1;
            S_ADVANCE: o_cmd.advance = 1'b1;
            S_CALC:    o_cmd.calc    = 1'b1;
            S_FINISH:  o_cmd.finish  = i_status.out_free;
            default:   o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `LPR_ASSERT_NEXT(a_sample_goes_advance, i_clk, i_rst_n,
        r_state == S_IDLE && i_in_valid && i_opcode != OP_SET,
        r_state == S_ADVANCE, "accepted sample transaction did not start advancing")
    `LPR_ASSERT_SAME(a_div_done_in_div, i_clk, i_rst_n, i_status.div_done,
        r_state == S_DIV, "divider finished outside the divide state")
endmodule

// ----- src/lpr_dp.sv -----
// Datapath of the linear parameter ramp: config registers, ramp state, arithmetic,
// output register. Depends on lpr_pkg, the channel interfaces, lpr_div, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module lpr_dp
    import lpr_pkg::*;
#(
    parameter int MIN_RAMP_LENGTH = MIN_RAMP_LENGTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    input  t_opcode                 i_opcode,
    input  logic signed [VAL_W-1:0] i_new_target,
    input  logic                    i_skip_ramp,
    input  logic signed [SMP_W-1:0] i_sample_in,
    lpr_cfg_if.sink                 i_cfg,
    lpr_out_if.source               o_out
);
    localparam logic [LEN_W-1:0]  MIN_LEN    = LEN_W'(MIN_RAMP_LENGTH);
    localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (SMP_W - 2);

    function automatic logic [MAG_W-1:0] mag(input logic [MAG_W-1:0] v);
        return v[MAG_W-1] ? (~v + MAG_W'(1)) : v;
    endfunction

    function automatic logic [VAL_W-1:0] sat(input logic [MAG_W-1:0] v);
        if (v[MAG_W-1] != v[MAG_W-2]) begin
            return v[MAG_W-1] ? VAL_MIN : VAL_MAX;
        end
        return v[VAL_W-1:0];
    endfunction

    logic [LEN_W-1:0]          r_ramp_len;
    logic [MINCH_W-1:0]        r_min_change;
    logic signed [VAL_W-1:0]   r_cur, r_tgt, r_step;
    t_opcode                   r_op;
    logic signed [VAL_W-1:0]   r_nt;
    logic                      r_skip;
    logic signed [SMP_W-1:0]   r_smp;
    logic                      r_big;
    logic                      r_neg;
    logic                      r_ramp_flag;
    logic signed [PROD_W-1:0]  r_prod;
    logic [MAG_W-1:0]          r_sum;
    logic                      r_out_valid;
    logic [VAL_W-1:0]          r_out_sample;
    logic                      r_out_ramping;

    logic [MAG_W-1:0]          w_diff, w_diff_mag;
    logic                      w_big;
    logic [LEN_W-1:0]          w_len;
    logic [MAG_W-1:0]          w_quo;
    logic                      w_div_done;
    logic [VAL_W-1:0]          w_step_new;
    logic [MAG_W-1:0]          w_quo_neg;
    logic [MAG_W-1:0]          w_dist, w_twostep, w_step_mag, w_cur_plus;
    logic                      w_go;
    logic signed [PROD_W-1:0]  w_round;
    logic [VAL_W-1:0]          w_result;

    assign i_cfg.ready = 1'b1;

    // Difference between the new target and the present value, 33 bits.
    assign w_diff     = {r_nt[VAL_W-1], r_nt} - {r_cur[VAL_W-1], r_cur};
    assign w_diff_mag = mag(w_diff);
    assign w_big      = w_diff_mag > MAG_W'(r_min_change);
    assign w_len      = (r_ramp_len < MIN_LEN) ? MIN_LEN : r_ramp_len;

    lpr_div #(
        .DVD_W (MAG_W),
        .DVS_W (LEN_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (w_diff_mag),
        .i_divisor  (w_len),
        .o_quotient (w_quo),
        .o_done     (w_div_done)
    );

    // The quotient magnitude exceeds the signed 32-bit range only for a length of one; clamp it.
    assign w_quo_neg = ~w_quo + MAG_W'(1);
    always_comb begin
        if (!r_neg) begin
            w_step_new = (w_quo > MAG_W'(VAL_MAX)) ? VAL_MAX : w_quo[VAL_W-1:0];
        end else begin
            w_step_new = (w_quo > MAG_W'(VAL_MIN)) ? VAL_MIN : w_quo_neg[VAL_W-1:0];
        end
    end

    assign w_dist     = mag({r_tgt[VAL_W-1], r_tgt} - {r_cur[VAL_W-1], r_cur});
    assign w_twostep  = mag({r_step, 1'b0});
    assign w_step_mag = mag({r_step[VAL_W-1], r_step});
    assign w_cur_plus = {r_cur[VAL_W-1], r_cur} + {r_step[VAL_W-1], r_step};
    assign w_go       = (w_dist > w_twostep) && (w_step_mag > MAG_W'(r_min_change));

    assign w_round = r_prod + $signed(ROUND_HALF);
    always_comb begin
        case (r_op)
            OP_ADD:  w_result = sat(r_sum);
            OP_MUL:  w_result = sat(w_round[PROD_W-1:SMP_W-1]);
            default: w_result = r_cur;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_len   <= RAMP_LENGTH_RESET;
            r_min_change <= MIN_CHANGE_RESET;
            r_cur        <= '0;
            r_tgt        <= '0;
            r_step       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.reg_index)
                    REG_RAMP_LENGTH: r_ramp_len   <= i_cfg.wr_data[LEN_W-1:0];
                    REG_MIN_CHANGE:  r_min_change <= i_cfg.wr_data[MINCH_W-1:0];
                    default:         r_ramp_len   <= r_ramp_len;
                endcase
            end
            if (i_cmd.update) begin
                if (r_big) begin
                    r_step <= w_step_new;
                end
                if (r_big || r_skip) begin
                    r_tgt <= r_nt;
                end
                if (r_skip) begin
                    r_cur <= r_nt;
                end
            end
            if (i_cmd.advance) begin
                r_cur <= w_go ? sat(w_cur_plus) : r_tgt;
            end
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (i_cmd.load) begin
            r_op   <= i_opcode;
            r_nt   <= i_new_target;
            r_skip <= i_skip_ramp;
            r_smp  <= i_sample_in;
        end
        if (i_cmd.check) begin
            r_big <= w_big;
            r_neg <= w_diff[MAG_W-1];
        end
        if (i_cmd.advance) begin
            r_ramp_flag <= w_go;
        end
        if (i_cmd.calc) begin
            r_prod <= r_cur * r_smp;
            r_sum  <= {r_cur[VAL_W-1], r_cur}
                    + {{(MAG_W-SMP_W-1){r_smp[SMP_W-1]}}, r_smp, 1'b0};
        end
        if (i_cmd.finish) begin
            r_out_sample  <= w_result;
            r_out_ramping <= r_ramp_flag;
        end
    end

    assign o_status.big_change = w_big;
    assign o_status.div_done   = w_div_done;
    assign o_status.out_free   = !r_out_valid || o_out.ready;

    assign o_out.valid      = r_out_valid;
    assign o_out.sample_out = r_out_sample;
    assign o_out.ramping    = r_out_ramping;

    `LPR_ASSERT_SAME(a_finish_needs_room, i_clk, i_rst_n, i_cmd.finish,
        !r_out_valid || o_out.ready, "result written over an untaken transaction")
endmodule

// ----- src/linear_parameter_ramp_top.sv -----
// Linear parameter ramp: smooths a Q8.24 parameter toward a target, applies it to samples.
// Input channel i_in takes one transaction per item. A set-target item (OP_SET) produces
// no result; it passes through check and update when the change is within min_change,
// and check, divide, update when the bit-serial divider in lpr_div computes a new step.
// Sample items (OP_ADD, OP_MUL, OP_EMIT) each produce one result on o_out. A sample item
// is accepted, then advanced, multiplied and rounded in turn; the block takes one sample
// item at a time and accepts the next only after the last has finished, the controller
// sequencing advance, multiply and saturate through one datapath.
// The result sits in an output register; a new item is accepted while it waits. When the
// receiver stalls, the block holds in its finishing step until the register frees.
// Configuration writes on i_cfg are always ready: index 0 ramp_length, index 1
// min_change. They are meant for idle periods only.
// Reset (i_rst_n low at a clock edge) restores ramp_length 480 and min_change 16,
// clears current value, target and step, and empties the output register.
// Depends on lpr_pkg, the channel interfaces, lpr_ctrl and lpr_dp.
`timescale 1ns / 1ps

module linear_parameter_ramp_top
    import lpr_pkg::*;
#(
    parameter int MIN_RAMP_LENGTH = MIN_RAMP_LENGTH_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lpr_in_if.sink    i_in,
    lpr_cfg_if.sink   i_cfg,
    lpr_out_if.source o_out
);
    t_cmd    w_cmd;
    t_status w_status;
    logic    w_in_ready;

    assign i_in.ready = w_in_ready;

    lpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_opcode   (i_in.opcode),
        .i_status   (w_status),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    lpr_dp #(
        .MIN_RAMP_LENGTH (MIN_RAMP_LENGTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_opcode     (i_in.opcode),
        .i_new_target (i_in.new_target),
        .i_skip_ramp  (i_in.skip_ramp),
        .i_sample_in  (i_in.sample_in),
        .i_cfg        (i_cfg),
        .o_out        (o_out)
    );
endmodule
